FILE: rtl/fcsb_pkg.sv
// Shared types and constants for the frustum culling block.
`timescale 1ns / 1ps

package fcsb_pkg;

    // Number of plane registers in the register map; this does not vary.
    localparam int unsigned PLANE_REGS = 6;
    localparam int unsigned PLANE_W    = 52;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned NORM_W     = 12;
    localparam int unsigned RADIUS_W   = 15;
    localparam int unsigned PROD_W     = COORD_W + NORM_W;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned FRAC_BITS  = 10;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned PADDR_W    = 6;
    localparam int unsigned PDATA_W    = 64;
    localparam int unsigned COUNT_W    = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PLANE_LAST    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PLANES_IN_USE = 3'd6;

    localparam logic [COUNT_W-1:0] PLANES_IN_USE_RST = 3'd6;

    localparam bit OP_SPHERE = 1'b0;
    localparam bit OP_BOX    = 1'b1;

    // Packed plane: normal x in the low bits, then y, z, then distance.
    typedef struct packed {
        logic signed [COORD_W-1:0]  distance;
        logic [2:0][NORM_W-1:0]     normal;
    } t_plane;

    // One volume as it travels down the cell chain.
    typedef struct packed {
        logic                        opcode;
        logic [2:0][COORD_W-1:0]     first;
        logic [2:0][COORD_W-1:0]     second;
        logic [RADIUS_W-1:0]         radius;
        logic                        batch_end;
        logic                        culled;
    } t_item;

endpackage

FILE: rtl/fcsb_cell.sv
// One plane cell: multiplies the volume against its plane, then sums and compares.
`timescale 1ns / 1ps

module fcsb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_active,
    input  fcsb_pkg::t_plane i_plane,
    input  logic            i_valid,
    output logic            o_ready,
    input  fcsb_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output fcsb_pkg::t_item o_item
);
    import fcsb_pkg::*;

    logic                      r_a_valid;
    t_item                     r_a_item;
    logic signed [PROD_W-1:0]  r_a_lo [3];
    logic signed [PROD_W-1:0]  r_a_hi [3];
    logic                      r_b_valid;
    t_item                     r_b_item;

    logic                      a_ready;
    logic                      b_ready;
    logic signed [PROD_W-1:0]  n_lo [3];
    logic signed [PROD_W-1:0]  n_hi [3];
    logic signed [SUM_W-1:0]   term [3];
    logic signed [SUM_W-1:0]   n_sum;
    logic                      hit;
    t_item                     n_b_item;

    // Each stage takes a new item when it is empty or its content moves on.
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = PROD_W'($signed(i_item.first[k])) * PROD_W'($signed(i_plane.normal[k]));
            n_hi[k] = PROD_W'($signed(i_item.second[k])) * PROD_W'($signed(i_plane.normal[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_item <= i_item;
            r_a_lo   <= n_lo;
            r_a_hi   <= n_hi;
        end
    end

    // A box takes the larger product per axis; a sphere uses its center only.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_a_item.opcode == OP_BOX && r_a_hi[k] > r_a_lo[k]) begin
                term[k] = SUM_W'(r_a_hi[k]);
            end else begin
                term[k] = SUM_W'(r_a_lo[k]);
            end
        end
        n_sum = term[0] + term[1] + term[2] +
                (SUM_W'($signed(i_plane.distance)) <<< FRAC_BITS);
        if (r_a_item.opcode == OP_SPHERE) begin
            n_sum = n_sum + (signed'(SUM_W'(r_a_item.radius)) <<< FRAC_BITS);
        end
        hit = i_active && (n_sum <= signed'(SUM_W'(0)));
        n_b_item        = r_a_item;
        n_b_item.culled = r_a_item.culled | hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_item <= n_b_item;
        end
    end

endmodule

FILE: rtl/frustum_cull_sphere_box.sv
// Top level of the frustum culler: register file and the chain of plane cells.
`timescale 1ns / 1ps

// Culls spheres and axis-aligned boxes against up to NUM_PLANES frustum planes.
// Each plane has its own cell of two register stages (a multiply stage and a
// sum-and-compare stage), and the cells form a chain, so one item enters per
// cycle while the output is not stalled; each item passes both stages of every
// cell in turn. Every stage holds its item only while the stage after it is
// full, so a waiting result does not keep new items out until the chain fills.
// Planes are programmed over the APB port at 8-byte steps (plane_0..plane_5 at
// 0x00..0x28, planes_in_use at 0x30); the user must do so only while no item
// is in flight, which the block itself does not enforce.

module frustum_cull_sphere_box #(
    parameter int unsigned NUM_PLANES = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [fcsb_pkg::PADDR_W-1:0]       i_paddr,
    input  logic [fcsb_pkg::PDATA_W-1:0]       i_pwdata,
    output logic [fcsb_pkg::PDATA_W-1:0]       o_prdata,
    output logic                               o_pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_opcode,
    input  logic signed [fcsb_pkg::COORD_W-1:0] i_first_x,
    input  logic signed [fcsb_pkg::COORD_W-1:0] i_first_y,
    input  logic signed [fcsb_pkg::COORD_W-1:0] i_first_z,
    input  logic signed [fcsb_pkg::COORD_W-1:0] i_second_x,
    input  logic signed [fcsb_pkg::COORD_W-1:0] i_second_y,
    input  logic signed [fcsb_pkg::COORD_W-1:0] i_second_z,
    input  logic [fcsb_pkg::RADIUS_W-1:0]      i_radius,
    input  logic                               i_batch_end,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_culled,
    output logic                               o_batch_end_out
);
    import fcsb_pkg::*;

    logic [PLANE_W-1:0]   r_plane [PLANE_REGS];
    logic [COUNT_W-1:0]   r_planes_in_use;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [COUNT_W-1:0]   plane_count;

    t_item                chain_item  [NUM_PLANES+1];
    logic                 chain_valid [NUM_PLANES+1];
    logic                 chain_ready [NUM_PLANES+1];

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_idx  = i_paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                r_plane[i] <= '0;
            end
            r_planes_in_use <= PLANES_IN_USE_RST;
        end else if (wr_en) begin
            if (reg_idx <= REG_PLANE_LAST) begin
                r_plane[reg_idx] <= i_pwdata[PLANE_W-1:0];
            end else if (reg_idx == REG_PLANES_IN_USE) begin
                r_planes_in_use <= i_pwdata[COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        if (reg_idx <= REG_PLANE_LAST) begin
            o_prdata = PDATA_W'(r_plane[reg_idx]);
        end else if (reg_idx == REG_PLANES_IN_USE) begin
            o_prdata = PDATA_W'(r_planes_in_use);
        end
    end

    // A count above the number of built cells tests all of them.
    assign plane_count = (r_planes_in_use > COUNT_W'(NUM_PLANES)) ?
                         COUNT_W'(NUM_PLANES) : r_planes_in_use;

    always_comb begin
        chain_item[0].opcode    = i_opcode;
        chain_item[0].first     = {i_first_z, i_first_y, i_first_x};
        chain_item[0].second    = {i_second_z, i_second_y, i_second_x};
        chain_item[0].radius    = i_radius;
        chain_item[0].batch_end = i_batch_end;
        chain_item[0].culled    = 1'b0;
    end
    assign chain_valid[0] = i_valid;
    assign o_ready        = chain_ready[0];

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        fcsb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_active(COUNT_W'(g) < plane_count),
            .i_plane (t_plane'(r_plane[g])),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_item  (chain_item[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_item  (chain_item[g+1])
        );
    end

    assign chain_ready[NUM_PLANES] = i_ready;
    assign o_valid         = chain_valid[NUM_PLANES];
    assign o_culled        = chain_item[NUM_PLANES].culled;
    assign o_batch_end_out = chain_item[NUM_PLANES].batch_end;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sphere and box frustum culler.
`timescale 1ns / 1ps

module testbench;

    import fcsb_pkg::*;

    localparam int unsigned NUM_PLANES = 6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int unsigned DRAIN_CYCLES = 2 * NUM_PLANES + 4;
    localparam int unsigned ITEMS_PER_PHASE = 135;
    localparam int unsigned NUM_PHASES = 8;

    typedef enum int {
        SETUP_NONE,
        SETUP_FRUSTUM,
        SETUP_NO_PLANES,
        SETUP_FIVE_PLANES,
        SETUP_COUNT_SEVEN
    } t_setup;

    typedef struct {
        bit                 kind;
        bit signed [15:0]   first[3];
        bit signed [15:0]   second[3];
        bit [14:0]          radius;
        bit                 batch_end;
    } t_volume;

    typedef struct {
        bit culled;
        bit batch_end;
    } t_verdict;

    typedef struct {
        t_setup     setup;
        t_volume    vol;
        bit         typed;
        bit         typed_culled;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_psel = 1'b0;
    logic                   i_penable = 1'b0;
    logic                   i_pwrite = 1'b0;
    logic [PADDR_W-1:0]     i_paddr = '0;
    logic [PDATA_W-1:0]     i_pwdata = '0;
    logic [PDATA_W-1:0]     o_prdata;
    logic                   o_pready;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_opcode = 1'b0;
    logic signed [15:0]     i_first_x = '0;
    logic signed [15:0]     i_first_y = '0;
    logic signed [15:0]     i_first_z = '0;
    logic signed [15:0]     i_second_x = '0;
    logic signed [15:0]     i_second_y = '0;
    logic signed [15:0]     i_second_z = '0;
    logic [RADIUS_W-1:0]    i_radius = '0;
    logic                   i_batch_end = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_culled;
    logic                   o_batch_end_out;

    // Shadow copy of the register file, updated as each write lands.
    bit [51:0]      plane_copy[PLANE_REGS];
    bit [2:0]       in_use_copy = 3'd6;

    t_verdict       pending_verdicts[$];
    t_row           directed_rows[$];
    int unsigned    error_count = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;

    frustum_cull_sphere_box #(
        .NUM_PLANES(NUM_PLANES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_psel(i_psel),
        .i_penable(i_penable),
        .i_pwrite(i_pwrite),
        .i_paddr(i_paddr),
        .i_pwdata(i_pwdata),
        .o_prdata(o_prdata),
        .o_pready(o_pready),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_first_x(i_first_x),
        .i_first_y(i_first_y),
        .i_first_z(i_first_z),
        .i_second_x(i_second_x),
        .i_second_y(i_second_y),
        .i_second_z(i_second_z),
        .i_radius(i_radius),
        .i_batch_end(i_batch_end),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_culled(o_culled),
        .o_batch_end_out(o_batch_end_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic bit predict_cull(t_volume v);
        longint lo[3];
        longint hi[3];
        longint nrm[3];
        longint acc;
        int unsigned planes;
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            lo[k] = v.first[k];
            hi[k] = v.second[k];
        end
        planes = (in_use_copy > NUM_PLANES) ? NUM_PLANES : in_use_copy;
        for (int p = 0; p < planes; p++) begin
            for (int k = 0; k < 3; k++)
                nrm[k] = longint'($signed(plane_copy[p][12*k +: 12]));
            acc = longint'($signed(plane_copy[p][51:36])) * 1024;
            if (v.kind == OP_BOX) begin
                for (int k = 0; k < 3; k++)
                    acc += (lo[k] * nrm[k] > hi[k] * nrm[k]) ? lo[k] * nrm[k] : hi[k] * nrm[k];
                if (acc <= 0)
                    hit = 1'b1;
            end else begin
                for (int k = 0; k < 3; k++)
                    acc += lo[k] * nrm[k];
                if (acc <= -(longint'(v.radius) * 1024))
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic bit [63:0] pack_plane(int nx, int ny, int nz, int distance);
        bit [63:0] word;
        // Upper bits are junk on purpose; the register keeps only 52 bits.
        word = {$urandom, $urandom};
        word[11:0] = nx[11:0];
        word[23:12] = ny[11:0];
        word[35:24] = nz[11:0];
        word[51:36] = distance[15:0];
        return word;
    endfunction

    function automatic bit signed [15:0] random_coord(bit near);
        if (near)
            return 16'($urandom_range(4000) - 2000);
        return 16'($urandom);
    endfunction

    function automatic t_volume random_volume();
        t_volume v;
        bit near;
        bit signed [15:0] tmp;
        near = ($urandom_range(9) < 4);
        v.kind = 1'($urandom_range(1));
        for (int k = 0; k < 3; k++) begin
            v.first[k] = random_coord(near);
            v.second[k] = random_coord(near);
            // Most boxes are well formed; the rest keep inverted corners.
            if (v.kind == OP_BOX && $urandom_range(9) < 7 && v.first[k] > v.second[k]) begin
                tmp = v.first[k];
                v.first[k] = v.second[k];
                v.second[k] = tmp;
            end
        end
        case ($urandom_range(5))
            0: v.radius = '0;
            1, 2: v.radius = 15'($urandom_range(32767));
            default: v.radius = 15'($urandom_range(3000));
        endcase
        v.batch_end = ($urandom_range(7) == 0);
        return v;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, bit [63:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 3'b000};
        i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        if (idx <= REG_PLANE_LAST)
            plane_copy[idx] = value[51:0];
        else if (idx == REG_PLANES_IN_USE)
            in_use_copy = value[2:0];
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_volume(t_volume v, bit typed, bit typed_culled);
        t_verdict want;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_opcode <= v.kind;
        i_first_x <= v.first[0];
        i_first_y <= v.first[1];
        i_first_z <= v.first[2];
        i_second_x <= v.second[0];
        i_second_y <= v.second[1];
        i_second_z <= v.second[2];
        i_radius <= v.radius;
        i_batch_end <= v.batch_end;
        do @(posedge i_clk); while (!o_ready);
        want.culled = typed ? typed_culled : predict_cull(v);
        want.batch_end = v.batch_end;
        pending_verdicts.push_back(want);
    endtask

    task automatic apply_setup(t_setup step);
        case (step)
            SETUP_FRUSTUM: begin
                write_reg(3'd0, pack_plane(1024, 0, 0, 0));
                write_reg(3'd1, pack_plane(-1024, 0, 0, 100));
                write_reg(3'd2, pack_plane(0, 2047, 0, 32767));
                write_reg(3'd3, pack_plane(0, 0, -2048, 32767));
                write_reg(3'd4, pack_plane(0, 1024, 0, 0));
                write_reg(REG_PLANE_LAST, pack_plane(0, 0, 1024, 32767));
                write_reg(REG_PLANES_IN_USE, 64'd6);
            end
            SETUP_NO_PLANES: write_reg(REG_PLANES_IN_USE, 64'd0);
            SETUP_FIVE_PLANES: begin
                // The last plane now rejects everything, but five planes skip it.
                write_reg(REG_PLANE_LAST, pack_plane(0, 0, 0, -32768));
                write_reg(REG_PLANES_IN_USE, 64'd5);
            end
            SETUP_COUNT_SEVEN: write_reg(REG_PLANES_IN_USE, {61'h155, 3'd7});
            default: ;
        endcase
    endtask

    task automatic add_row(t_setup setup, bit kind, int fx, int fy, int fz, int sx, int sy,
                           int sz, int rad, bit be, bit typed, bit typed_culled);
        t_row row;
        row.setup = setup;
        row.vol.kind = kind;
        row.vol.first[0] = fx[15:0];
        row.vol.first[1] = fy[15:0];
        row.vol.first[2] = fz[15:0];
        row.vol.second[0] = sx[15:0];
        row.vol.second[1] = sy[15:0];
        row.vol.second[2] = sz[15:0];
        row.vol.radius = rad[14:0];
        row.vol.batch_end = be;
        row.typed = typed;
        row.typed_culled = typed_culled;
        directed_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                note_mismatch("result with no item pending, culled", -1, o_culled);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_culled !== want.culled)
                    note_mismatch("culled", want.culled, o_culled);
                if (o_batch_end_out !== want.batch_end)
                    note_mismatch("batch_end_out", want.batch_end, o_batch_end_out);
            end
        end
    end

    initial begin : stimulus
        int unsigned counts[NUM_PHASES];
        bit extreme;
        int nrm[3];
        int distance;
        counts = '{6, 4, 5, 6, 4, 2, 7, 6};

        // With every plane zero, a box always sits on the boundary and is culled,
        // while a sphere is culled only when its radius is zero.
        add_row(SETUP_NONE, OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
        add_row(SETUP_NONE, OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 1, 1'b1, 1'b1, 1'b0);
        add_row(SETUP_NONE, OP_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                1'b0, 1'b1, 1'b0);
        add_row(SETUP_NONE, OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                1'b1, 1'b1, 1'b1);
        add_row(SETUP_NONE, OP_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0,
                1'b0, 1'b1, 1'b1);
        add_row(SETUP_NONE, OP_SPHERE, 5, -7, 9, -32768, 32767, -1, 0, 1'b1, 1'b1, 1'b1);
        // Spheres touching and just clearing the first plane, boxes on and past planes.
        add_row(SETUP_FRUSTUM, OP_SPHERE, -5, 50, 0, 0, 0, 0, 5, 1'b0, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_SPHERE, -4, 50, 0, 0, 0, 0, 5, 1'b1, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_SPHERE, 50, 50, 10, -1, -1, -1, 0, 1'b0, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_BOX, -10, 0, 0, 0, 10, 10, 32767, 1'b0, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_BOX, 101, 0, 0, 200, 5, 5, 0, 1'b1, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_BOX, 90, 20, 12, 10, 5, 3, 0, 1'b0, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_SPHERE, 32767, 32767, -32768, 0, 0, 0, 32767, 1'b0, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0,
                1'b1, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        add_row(SETUP_NO_PLANES, OP_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0,
                1'b1, 1'b1, 1'b0);
        add_row(SETUP_NONE, OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0);
        add_row(SETUP_FIVE_PLANES, OP_SPHERE, 50, 50, 10, 0, 0, 0, 10, 1'b1, 1'b0, 1'b0);
        add_row(SETUP_NONE, OP_BOX, 0, 0, 0, 10, 10, 10, 0, 1'b0, 1'b0, 1'b0);
        // A count of seven is clamped to six, so the reject-all plane is tested.
        add_row(SETUP_COUNT_SEVEN, OP_SPHERE, 50, 50, 10, 0, 0, 0, 32767, 1'b1, 1'b1, 1'b1);
        add_row(SETUP_NONE, OP_BOX, -100, -100, -100, 100, 100, 100, 0, 1'b0, 1'b1, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].setup != SETUP_NONE) begin
                wait_drained();
                apply_setup(directed_rows[r].setup);
            end
            send_volume(directed_rows[r].vol, directed_rows[r].typed,
                        directed_rows[r].typed_culled);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            extreme = (phase == 0 || phase == 3);
            for (int p = 0; p <= REG_PLANE_LAST; p++) begin
                if (extreme) begin
                    for (int k = 0; k < 3; k++) begin
                        case ($urandom_range(4))
                            0: nrm[k] = -2048;
                            1: nrm[k] = 2047;
                            2: nrm[k] = 0;
                            3: nrm[k] = -1024;
                            default: nrm[k] = 1024;
                        endcase
                    end
                    case ($urandom_range(2))
                        0: distance = -32768;
                        1: distance = 32767;
                        default: distance = 0;
                    endcase
                    write_reg(p[REG_IDX_W-1:0], pack_plane(nrm[0], nrm[1], nrm[2], distance));
                end else begin
                    write_reg(p[REG_IDX_W-1:0], {$urandom, $urandom});
                end
            end
            write_reg(REG_PLANES_IN_USE, {$urandom, 29'($urandom), 3'(counts[phase])});
            write_reg(REG_UNMAPPED, {$urandom, $urandom});

            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 77; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 77; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            repeat (ITEMS_PER_PHASE) send_volume(random_volume(), 1'b0, 1'b0);
        end

        wait_drained();
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
